// File: src/lcar_pkg.sv
// Shared types, codes and constants for the load cell ADC reader.
package lcar_pkg;

   // Sample and field widths
   localparam int SAMPLE_BITS = 24;
   localparam int TIMES_W     = 8;
   localparam int NET_W       = 25;
   localparam int UNITS_W     = 33;
   localparam int SUM_W       = 32;
   localparam int SCALE_W     = 32;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;

   // Divider sizing: dividend is |net| shifted up by 24, divisor is the scale
   localparam int DIV_W     = 48;
   localparam int DVSR_W    = 32;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // Smallest usable scale (1.0 in Q16.16)
   localparam logic [SCALE_W-1:0] SCALE_MIN = 32'h0001_0000;

   // Operation codes carried by each input word
   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_MEASURE  = 3'd1,
      OP_TARE     = 3'd2,
      OP_PDOWN    = 3'd3,
      OP_PUP      = 3'd4,
      OP_LOAD_OFS = 3'd5
   } op_type;

   // Gain select codes
   typedef enum logic [1:0] {
      GAIN_128  = 2'd0,
      GAIN_64   = 2'd1,
      GAIN_32   = 2'd2,
      GAIN_NONE = 2'd3
   } gain_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN  = 1'd0,
      CSR_SCALE = 1'd1
   } csr_type;

   // Serial link phase
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_WAIT  = 2'd1,
      PH_BITS  = 2'd2,
      PH_PULSE = 2'd3
   } phase_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE       = 3'd0,
      ST_STEP       = 3'd1,
      ST_AVG_GO     = 3'd2,
      ST_AVG_WAIT   = 3'd3,
      ST_UNITS_GO   = 3'd4,
      ST_UNITS_WAIT = 3'd5,
      ST_OUT        = 3'd6
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic latch_in;
      logic step;
      logic div_start;
      logic div_units;
      logic take_avg;
      logic take_units;
      logic load_out;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic last_tick;
      logic div_busy;
   } sts_type;

endpackage

// File: src/lcar_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module lcar_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lcar_pkg::DIV_W-1:0]   dividend,
   input  logic [lcar_pkg::DVSR_W-1:0]  divisor,
   output logic                         busy,
   output logic [lcar_pkg::DIV_W-1:0]   quotient
);

   logic                             busy_ff, busy_in;
   logic [lcar_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [lcar_pkg::DVSR_W-1:0]      rem_ff, rem_in;
   logic [lcar_pkg::DVSR_W-1:0]      dvsr_ff, dvsr_in;
   logic [lcar_pkg::DIV_W-1:0]       quot_ff, quot_in;
   logic [lcar_pkg::DVSR_W:0]        trial;
   logic [lcar_pkg::DVSR_W:0]        diff;

   // Shift in the next dividend bit and try the subtract
   always_comb begin
      trial   = {rem_ff, quot_ff[lcar_pkg::DIV_W-1]};
      diff    = trial - {1'b0, dvsr_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = lcar_pkg::DIV_CNT_W'(lcar_pkg::DIV_W - 1);
         rem_in  = '0;
         dvsr_in = divisor;
         quot_in = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvsr_ff}) begin
            rem_in  = diff[lcar_pkg::DVSR_W-1:0];
            quot_in = {quot_ff[lcar_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[lcar_pkg::DVSR_W-1:0];
            quot_in = {quot_ff[lcar_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
      quot_ff <= quot_in;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

// File: src/lcar_dp.sv
// Datapath: link state, sample accumulation, offset, scaling and output word.
module lcar_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lcar_pkg::cmd_type                     cmd,
   output lcar_pkg::sts_type                     sts,
   // input word fields
   input  logic [2:0]                            req_operation,
   input  logic                                  req_data_in,
   input  logic [lcar_pkg::TIMES_W-1:0]          req_times,
   input  logic signed [lcar_pkg::SAMPLE_BITS-1:0] req_offset_value,
   // configuration writes
   input  logic                                  csr_write,
   input  logic [lcar_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lcar_pkg::CSR_DATA_W-1:0]       csr_wdata,
   // result word
   output logic                                  rsp_clock_out,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_done_res,
   output logic signed [lcar_pkg::SAMPLE_BITS-1:0] rsp_average,
   output logic signed [lcar_pkg::NET_W-1:0]     rsp_net_value,
   output logic signed [lcar_pkg::UNITS_W-1:0]   rsp_units_q8
);

   localparam int SB = lcar_pkg::SAMPLE_BITS;

   // configuration
   logic [1:0]                      gain_ff;
   logic [lcar_pkg::SCALE_W-1:0]    scale_ff;

   // latched input word
   logic [2:0]                      op_ff;
   logic                            din_ff;
   logic [lcar_pkg::TIMES_W-1:0]    tms_ff;
   logic [SB-1:0]                   offv_ff;

   // link and accumulation state
   lcar_pkg::phase_type             phase_ff, phase_in;
   logic [4:0]                      bit_ff, bit_in;
   logic [1:0]                      pulse_ff, pulse_in;
   logic [lcar_pkg::TIMES_W-1:0]    read_ff, read_in;
   logic [SB-1:0]                   shift_ff, shift_in;
   logic signed [lcar_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [lcar_pkg::TIMES_W-1:0]    times_ff, times_in;
   logic signed [SB-1:0]            offset_ff, offset_in;
   logic                            clk_ff, clk_in;
   logic                            tare_ff, tare_in;
   logic                            pdown_ff, pdown_in;
   logic                            last_in;

   // pending result
   logic                            res_clk_ff;
   logic                            res_busy_ff;
   logic                            res_done_ff;
   logic signed [SB-1:0]            res_avg_ff;
   logic signed [lcar_pkg::NET_W-1:0]   res_net_ff;
   logic signed [lcar_pkg::UNITS_W-1:0] res_units_ff;
   logic                            net_neg_ff;

   // output register
   logic                            out_clk_ff;
   logic                            out_busy_ff;
   logic                            out_done_ff;
   logic signed [SB-1:0]            out_avg_ff;
   logic signed [lcar_pkg::NET_W-1:0]   out_net_ff;
   logic signed [lcar_pkg::UNITS_W-1:0] out_units_ff;

   // step helpers
   logic [1:0]                      pulses_wanted;
   logic [SB-1:0]                   sample;
   logic [5:0]                      bit_inc;
   logic [2:0]                      pulse_inc;
   logic [lcar_pkg::TIMES_W:0]      read_inc;

   // division operands and results
   logic [lcar_pkg::SUM_W-1:0]      sum_mag;
   logic signed [lcar_pkg::NET_W-1:0] net_val;
   logic [lcar_pkg::NET_W-1:0]      net_mag;
   logic [lcar_pkg::SCALE_W-1:0]    scale_eff;
   logic [lcar_pkg::DIV_W-1:0]      div_dividend;
   logic [lcar_pkg::DVSR_W-1:0]     div_divisor;
   logic                            div_busy;
   logic [lcar_pkg::DIV_W-1:0]      div_quot;
   logic [SB-1:0]                   avg_val;
   logic [lcar_pkg::UNITS_W-1:0]    units_val;

   // Gain pulses per reading
   always_comb begin
      unique case (gain_ff)
         lcar_pkg::GAIN_64: pulses_wanted = 2'd3;
         lcar_pkg::GAIN_32: pulses_wanted = 2'd2;
         default:           pulses_wanted = 2'd1;
      endcase
   end

   // Negate the raw code; the most negative code wraps onto itself
   assign sample    = ~shift_ff + 1'b1;
   assign bit_inc   = {1'b0, bit_ff} + 6'd1;
   assign pulse_inc = {1'b0, pulse_ff} + 3'd1;
   assign read_inc  = {1'b0, read_ff} + 1'b1;

   // Advance the link by one half period
   always_comb begin
      phase_in  = phase_ff;
      bit_in    = bit_ff;
      pulse_in  = pulse_ff;
      read_in   = read_ff;
      shift_in  = shift_ff;
      sum_in    = sum_ff;
      times_in  = times_ff;
      offset_in = offset_ff;
      clk_in    = clk_ff;
      tare_in   = tare_ff;
      pdown_in  = pdown_ff;
      last_in   = 1'b0;
      unique case (phase_ff)
         lcar_pkg::PH_IDLE: begin
            if ((op_ff == lcar_pkg::OP_MEASURE || op_ff == lcar_pkg::OP_TARE) && !pdown_ff) begin
               times_in = (tms_ff == '0) ? lcar_pkg::TIMES_W'(1) : tms_ff;
               tare_in  = (op_ff == lcar_pkg::OP_TARE);
               read_in  = '0;
               sum_in   = '0;
               clk_in   = 1'b0;
               phase_in = lcar_pkg::PH_WAIT;
            end else if (op_ff == lcar_pkg::OP_PDOWN) begin
               pdown_in = 1'b1;
               clk_in   = 1'b1;
            end else if (op_ff == lcar_pkg::OP_PUP) begin
               pdown_in = 1'b0;
               clk_in   = 1'b0;
            end else if (op_ff == lcar_pkg::OP_LOAD_OFS) begin
               offset_in = offv_ff;
            end
         end
         lcar_pkg::PH_WAIT: begin
            if (!din_ff) begin
               bit_in   = '0;
               shift_in = '0;
               phase_in = lcar_pkg::PH_BITS;
            end
         end
         default: begin
            if (!clk_ff) begin
               clk_in = 1'b1;
            end else begin
               clk_in = 1'b0;
               if (phase_ff == lcar_pkg::PH_BITS) begin
                  shift_in = {shift_ff[SB-2:0], din_ff};
                  bit_in   = bit_inc[4:0];
                  if (bit_inc >= 6'(SB)) begin
                     pulse_in = '0;
                     phase_in = lcar_pkg::PH_PULSE;
                  end
               end else begin
                  pulse_in = pulse_inc[1:0];
                  if (pulse_inc >= {1'b0, pulses_wanted}) begin
                     pulse_in = '0;
                     sum_in   = sum_ff + lcar_pkg::SUM_W'(signed'(sample));
                     read_in  = read_inc[lcar_pkg::TIMES_W-1:0];
                     if (read_inc >= {1'b0, times_ff}) begin
                        last_in  = 1'b1;
                        phase_in = lcar_pkg::PH_IDLE;
                     end else begin
                        phase_in = lcar_pkg::PH_WAIT;
                     end
                  end
               end
            end
         end
      endcase
   end

   // Select divider operands: sum by times, or |net| * 2^24 by scale
   assign sum_mag   = sum_ff[lcar_pkg::SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;
   assign net_val   = lcar_pkg::NET_W'(res_avg_ff) - lcar_pkg::NET_W'(offset_ff);
   assign net_mag   = net_val[lcar_pkg::NET_W-1] ? (~net_val + 1'b1) : net_val;
   assign scale_eff = (scale_ff < lcar_pkg::SCALE_MIN) ? lcar_pkg::SCALE_MIN : scale_ff;

   always_comb begin
      if (cmd.div_units) begin
         div_dividend = {net_mag[SB-1:0], SB'(0)};
         div_divisor  = scale_eff;
      end else begin
         div_dividend = lcar_pkg::DIV_W'(sum_mag);
         div_divisor  = lcar_pkg::DVSR_W'(times_ff);
      end
   end

   lcar_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   // Restore the sign: truncation toward zero
   assign avg_val   = sum_ff[lcar_pkg::SUM_W-1] ? (~div_quot[SB-1:0] + 1'b1) : div_quot[SB-1:0];
   assign units_val = net_neg_ff ? (~div_quot[lcar_pkg::UNITS_W-1:0] + 1'b1)
                                 : div_quot[lcar_pkg::UNITS_W-1:0];

   assign sts.last_tick = last_in;
   assign sts.div_busy  = div_busy;

   // Control state: link, accumulation, offset and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= lcar_pkg::GAIN_128;
         scale_ff  <= lcar_pkg::SCALE_MIN;
         phase_ff  <= lcar_pkg::PH_IDLE;
         bit_ff    <= '0;
         pulse_ff  <= '0;
         read_ff   <= '0;
         shift_ff  <= '0;
         sum_ff    <= '0;
         times_ff  <= lcar_pkg::TIMES_W'(1);
         offset_ff <= '0;
         clk_ff    <= 1'b0;
         tare_ff   <= 1'b0;
         pdown_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            if (csr_index == lcar_pkg::CSR_GAIN) begin
               if (csr_wdata[1:0] != lcar_pkg::GAIN_NONE) begin
                  gain_ff <= csr_wdata[1:0];
               end
            end else begin
               scale_ff <= csr_wdata;
            end
         end
         if (cmd.step) begin
            phase_ff  <= phase_in;
            bit_ff    <= bit_in;
            pulse_ff  <= pulse_in;
            read_ff   <= read_in;
            shift_ff  <= shift_in;
            sum_ff    <= sum_in;
            times_ff  <= times_in;
            offset_ff <= offset_in;
            clk_ff    <= clk_in;
            tare_ff   <= tare_in;
            pdown_ff  <= pdown_in;
         end
         // tare takes the new average as offset before net is formed
         if (cmd.take_avg) begin
            tare_ff <= 1'b0;
            if (tare_ff) begin
               offset_ff <= avg_val;
            end
         end
      end
   end

   // Payload: latched input, pending result and output word
   always_ff @(posedge clock) begin
      if (cmd.latch_in) begin
         op_ff   <= req_operation;
         din_ff  <= req_data_in;
         tms_ff  <= req_times;
         offv_ff <= req_offset_value;
      end
      if (cmd.step) begin
         res_clk_ff   <= clk_in;
         res_busy_ff  <= (phase_in != lcar_pkg::PH_IDLE);
         res_done_ff  <= last_in;
         res_avg_ff   <= '0;
         res_net_ff   <= '0;
         res_units_ff <= '0;
      end
      if (cmd.take_avg) begin
         res_avg_ff <= avg_val;
      end
      if (cmd.div_start && cmd.div_units) begin
         res_net_ff <= net_val;
         net_neg_ff <= net_val[lcar_pkg::NET_W-1];
      end
      if (cmd.take_units) begin
         res_units_ff <= units_val;
      end
      if (cmd.load_out) begin
         out_clk_ff   <= res_clk_ff;
         out_busy_ff  <= res_busy_ff;
         out_done_ff  <= res_done_ff;
         out_avg_ff   <= res_avg_ff;
         out_net_ff   <= res_net_ff;
         out_units_ff <= res_units_ff;
      end
   end

   assign rsp_clock_out = out_clk_ff;
   assign rsp_busy_res  = out_busy_ff;
   assign rsp_done_res  = out_done_ff;
   assign rsp_average   = out_avg_ff;
   assign rsp_net_value = out_net_ff;
   assign rsp_units_q8  = out_units_ff;

endmodule

// File: src/lcar_ctrl.sv
// Controller: sequences accept, step, the two divisions and the output load.
module lcar_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  lcar_pkg::sts_type sts,
   output lcar_pkg::cmd_type cmd
);

   lcar_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                slot_free;

   assign accept    = req_valid && (state_ff == lcar_pkg::ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcar_pkg::ST_IDLE:       if (accept) state_in = lcar_pkg::ST_STEP;
         lcar_pkg::ST_STEP: begin
            state_in = sts.last_tick ? lcar_pkg::ST_AVG_GO : lcar_pkg::ST_OUT;
         end
         lcar_pkg::ST_AVG_GO:     state_in = lcar_pkg::ST_AVG_WAIT;
         lcar_pkg::ST_AVG_WAIT:   if (!sts.div_busy) state_in = lcar_pkg::ST_UNITS_GO;
         lcar_pkg::ST_UNITS_GO:   state_in = lcar_pkg::ST_UNITS_WAIT;
         lcar_pkg::ST_UNITS_WAIT: if (!sts.div_busy) state_in = lcar_pkg::ST_OUT;
         lcar_pkg::ST_OUT:        if (slot_free) state_in = lcar_pkg::ST_IDLE;
         default:                 state_in = lcar_pkg::ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd            = '0;
      cmd.latch_in   = accept;
      cmd.step       = (state_ff == lcar_pkg::ST_STEP);
      cmd.div_start  = (state_ff == lcar_pkg::ST_AVG_GO) ||
                       (state_ff == lcar_pkg::ST_UNITS_GO);
      cmd.div_units  = (state_ff == lcar_pkg::ST_UNITS_GO);
      cmd.take_avg   = (state_ff == lcar_pkg::ST_AVG_WAIT) && !sts.div_busy;
      cmd.take_units = (state_ff == lcar_pkg::ST_UNITS_WAIT) && !sts.div_busy;
      cmd.load_out   = (state_ff == lcar_pkg::ST_OUT) && slot_free;
   end

   // Hold the output word until taken
   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcar_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != lcar_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: src/load_cell_adc_reader.sv
// Top level: load cell ADC reader, one result word for each tick word.
// Ordinary ticks go from accept through the step state to the output register; the tick that
// ends a measure or tare also passes two divider runs (mean, then scaling) before the output.
// One word in flight: the next word is accepted the cycle after the result is loaded,
// even while that result still waits to be taken.
// Reset (synchronous, active high): link idle, offset zero, gain 128, scale 1.0.
module load_cell_adc_reader (
   input  logic                                  clock,
   input  logic                                  reset,
   // tick words
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [2:0]                            req_operation,
   input  logic                                  req_data_in,
   input  logic [lcar_pkg::TIMES_W-1:0]          req_times,
   input  logic signed [lcar_pkg::SAMPLE_BITS-1:0] req_offset_value,
   // result words
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_clock_out,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_done_res,
   output logic signed [lcar_pkg::SAMPLE_BITS-1:0] rsp_average,
   output logic signed [lcar_pkg::NET_W-1:0]     rsp_net_value,
   output logic signed [lcar_pkg::UNITS_W-1:0]   rsp_units_q8,
   // configuration writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lcar_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lcar_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   lcar_pkg::cmd_type cmd;
   lcar_pkg::sts_type sts;

   // Registers take a write on any cycle
   assign csr_ready = 1'b1;

   lcar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lcar_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_operation    (req_operation),
      .req_data_in      (req_data_in),
      .req_times        (req_times),
      .req_offset_value (req_offset_value),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_clock_out    (rsp_clock_out),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_average      (rsp_average),
      .rsp_net_value    (rsp_net_value),
      .rsp_units_q8     (rsp_units_q8)
   );

endmodule

// File: src/lcar_chk.sv
// Port-level checker for the load cell ADC reader, bound to the top level.
module lcar_chk (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic                                  rsp_busy_res,
   input logic                                  rsp_done_res,
   input logic signed [lcar_pkg::SAMPLE_BITS-1:0] rsp_average,
   input logic signed [lcar_pkg::NET_W-1:0]     rsp_net_value,
   input logic signed [lcar_pkg::UNITS_W-1:0]   rsp_units_q8
);

   // Output word is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // A stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_average) &&
                                 $stable(rsp_units_q8) && $stable(rsp_done_res))
      else $error("stalled result word changed");

   // One word at a time: stall follows every accepted word
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted while one in flight");

   // A finished sequence leaves the link idle
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done reported while busy");

   // Results are zero on ticks that finish nothing
   a_zero_when_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |->
         rsp_average == '0 && rsp_net_value == '0 && rsp_units_q8 == '0)
      else $error("nonzero result on a tick that is not done");

endmodule

bind load_cell_adc_reader lcar_chk u_lcar_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_busy_res  (rsp_busy_res),
   .rsp_done_res  (rsp_done_res),
   .rsp_average   (rsp_average),
   .rsp_net_value (rsp_net_value),
   .rsp_units_q8  (rsp_units_q8)
);
